/* rtl/qkadj_pkg.sv */
// package for the quadrature knob setting adjuster
// transaction structs, mode and step codes, register indexes and constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qkadj_pkg;

    // widths fixed by the transaction fields
    localparam int unsigned SP_FIELD_W  = 10;
    localparam int unsigned DUR_W       = 16;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned STEP_W      = 2;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam int unsigned SETPOINT_WIDTH_DEFAULT = 10;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CEILING = 1'b1;

    localparam logic [SP_FIELD_W-1:0] CEILING_RESET = 10'h3FF;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_OTHER          = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WAIT_START     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CHOOSE_MANUAL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHOOSE_PROFILE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MANUAL         = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COUNTDOWN_SET  = 3'd5;

    // step codes
    localparam logic [STEP_W-1:0] STEP_NONE = 2'd0;
    localparam logic [STEP_W-1:0] STEP_CW   = 2'd1;
    localparam logic [STEP_W-1:0] STEP_ACW  = 2'd2;

    localparam logic [DUR_W-1:0]   DUR_TOP     = 16'd59940;
    localparam logic [DUR_W-1:0]   DUR_STEP    = 16'd60;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 3'd3;

    typedef struct packed {
        logic              quad_changed;
        logic [1:0]        quad_pins;
        logic              button_changed;
        logic              button_level;
        logic [MODE_W-1:0] ui_mode;
    } knob_in_t;

    typedef struct packed {
        logic [MODE_W-1:0]     next_mode;
        logic [STEP_W-1:0]     step_taken;
        logic [SP_FIELD_W-1:0] setpoint_value;
        logic [DUR_W-1:0]      duration_seconds;
        logic                  button_held;
    } knob_out_t;

endpackage

`default_nettype wire

/* rtl/quadrature_knob_setting_adjuster.sv */
// quadrature knob setting adjuster: encoder step counting, mode, setpoint and duration
// depends on qkadj_pkg
// an input transaction passes the input register and then the result register
// one transaction per cycle, sustained while the result side keeps taking
// in_ready stays high while the input register is empty or moves on this cycle;
// both registers advance together when the result register is free or being drained
// reset (rst_n, async, active low): pipeline empty, counters, pins, setpoint,
// duration and button flag cleared, floor 0, ceiling 1023 masked to the width
`timescale 1ns / 1ps
`default_nettype none

module quadrature_knob_setting_adjuster #(
    parameter int unsigned SETPOINT_WIDTH = qkadj_pkg::SETPOINT_WIDTH_DEFAULT
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  qkadj_pkg::knob_in_t                     in_data,
    output logic                                    out_valid,
    input  wire                                     out_ready,
    output qkadj_pkg::knob_out_t                    out_data,
    input  wire                                     cfg_write,
    input  wire  [qkadj_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire  [qkadj_pkg::SP_FIELD_W-1:0]        cfg_data
);

    import qkadj_pkg::*;

    // common width for setpoint arithmetic: room for the field, the store and a sign
    localparam int unsigned CW = ((SETPOINT_WIDTH > SP_FIELD_W) ? SETPOINT_WIDTH
                                                                : SP_FIELD_W) + 2;
    localparam logic [CW-1:0] CEIL_RESET_EXT = CW'(CEILING_RESET);

    // pipeline registers
    logic      in_valid_reg;
    knob_in_t  in_data_reg;
    logic      out_valid_reg;
    knob_out_t out_data_reg;
    logic      advance;

    // configuration, already masked to the setpoint width
    logic [SETPOINT_WIDTH-1:0] floor_reg;
    logic [SETPOINT_WIDTH-1:0] ceiling_reg;
    logic [CW-1:0]             cfg_ext;

    // block state
    logic [1:0]                prev_pins_reg, prev_pins_next;
    logic [COUNT_W-1:0]        cw_count_reg, cw_count_next;
    logic [COUNT_W-1:0]        acw_count_reg, acw_count_next;
    logic [SETPOINT_WIDTH-1:0] setpoint_reg, setpoint_next;
    logic [DUR_W-1:0]          duration_reg, duration_next;
    logic                      button_reg, button_next;

    // combinational working signals
    logic               do_step;
    logic               step_cw;
    logic [STEP_W-1:0]  step_code;
    logic [MODE_W-1:0]  mode_next;
    logic [COUNT_W-1:0] cw_inc;
    logic [COUNT_W-1:0] acw_inc;
    logic signed [CW-1:0] sp_ext;
    logic signed [CW-1:0] sp_try;
    logic signed [CW-1:0] sp_clamped;
    logic signed [CW-1:0] floor_ext;
    logic signed [CW-1:0] ceil_ext;
    logic [CW-1:0]        sp_out_ext;
    knob_out_t            out_next;

    // handshake: result register frees up when drained, input register follows it
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cfg_ext = CW'(cfg_data);

    // next state for the item in the input register
    always_comb
    begin
        mode_next      = in_data_reg.ui_mode;
        step_code      = STEP_NONE;
        do_step        = 1'b0;
        step_cw        = 1'b0;
        prev_pins_next = prev_pins_reg;
        cw_count_next  = cw_count_reg;
        acw_count_next = acw_count_reg;
        setpoint_next  = setpoint_reg;
        duration_next  = duration_reg;
        button_next    = button_reg;
        cw_inc         = cw_count_reg + COUNT_W'(1);
        acw_inc        = acw_count_reg + COUNT_W'(1);

        // a quadrature event masks any button event arriving with it
        if (in_data_reg.quad_changed)
        begin
            if (in_data_reg.quad_pins != prev_pins_reg)
            begin
                // new channel a against old channel b gives the direction
                if (in_data_reg.quad_pins[0] ^ prev_pins_reg[1])
                begin
                    if (acw_inc > COUNT_LIMIT)
                    begin
                        acw_count_next = '0;
                        cw_count_next  = '0;
                        step_code      = STEP_ACW;
                        do_step        = 1'b1;
                    end
                    else
                    begin
                        acw_count_next = acw_inc;
                    end
                end
                else
                begin
                    if (cw_inc > COUNT_LIMIT)
                    begin
                        acw_count_next = '0;
                        cw_count_next  = '0;
                        step_code      = STEP_CW;
                        do_step        = 1'b1;
                        step_cw        = 1'b1;
                    end
                    else
                    begin
                        cw_count_next = cw_inc;
                    end
                end
            end
            prev_pins_next = in_data_reg.quad_pins;
        end
        else if (in_data_reg.button_changed)
        begin
            if (in_data_reg.button_level)
            begin
                // release advances the mode
                priority if (in_data_reg.ui_mode == MODE_WAIT_START)
                    mode_next = MODE_COUNTDOWN_SET;
                else if (in_data_reg.ui_mode == MODE_CHOOSE_MANUAL)
                    mode_next = MODE_MANUAL;
                else if (in_data_reg.ui_mode == MODE_CHOOSE_PROFILE)
                    mode_next = MODE_WAIT_START;
                else
                    mode_next = in_data_reg.ui_mode;
                button_next = 1'b0;
            end
            else
            begin
                button_next = 1'b1;
            end
        end

        // setpoint candidate, ceiling first then floor so the floor wins
        sp_ext     = signed'(CW'(setpoint_reg));
        floor_ext  = signed'(CW'(floor_reg));
        ceil_ext   = signed'(CW'(ceiling_reg));
        sp_try     = step_cw ? (sp_ext + CW'(1)) : (sp_ext - CW'(1));
        sp_clamped = sp_try;
        if (sp_clamped > ceil_ext)
            sp_clamped = ceil_ext;
        if (sp_clamped < floor_ext)
            sp_clamped = floor_ext;

        if (do_step)
        begin
            unique case (in_data_reg.ui_mode)
                MODE_WAIT_START:
                begin
                    // duration wraps between zero and the top value
                    if (step_cw)
                        duration_next = (duration_reg == DUR_TOP) ? '0
                                                                  : duration_reg + DUR_STEP;
                    else
                        duration_next = (duration_reg == '0) ? DUR_TOP
                                                             : duration_reg - DUR_STEP;
                end
                MODE_CHOOSE_MANUAL:  mode_next = MODE_CHOOSE_PROFILE;
                MODE_CHOOSE_PROFILE: mode_next = MODE_CHOOSE_MANUAL;
                MODE_MANUAL:         setpoint_next = sp_clamped[SETPOINT_WIDTH-1:0];
                default:             mode_next = in_data_reg.ui_mode;
            endcase
        end

        sp_out_ext                = CW'(setpoint_next);
        out_next.next_mode        = mode_next;
        out_next.step_taken       = step_code;
        out_next.setpoint_value   = sp_out_ext[SP_FIELD_W-1:0];
        out_next.duration_seconds = duration_next;
        out_next.button_held      = button_next;
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance && in_valid_reg)
            out_data_reg <= out_next;
    end

    // block state moves as the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
            cw_count_reg  <= '0;
            acw_count_reg <= '0;
            setpoint_reg  <= '0;
            duration_reg  <= '0;
            button_reg    <= 1'b0;
        end
        else if (advance && in_valid_reg)
        begin
            prev_pins_reg <= prev_pins_next;
            cw_count_reg  <= cw_count_next;
            acw_count_reg <= acw_count_next;
            setpoint_reg  <= setpoint_next;
            duration_reg  <= duration_next;
            button_reg    <= button_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= '0;
            ceiling_reg <= CEIL_RESET_EXT[SETPOINT_WIDTH-1:0];
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FLOOR:   floor_reg   <= cfg_ext[SETPOINT_WIDTH-1:0];
                CFG_CEILING: ceiling_reg <= cfg_ext[SETPOINT_WIDTH-1:0];
                default:     floor_reg   <= floor_reg;
            endcase
        end
    end

    // checks
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cw_count_reg <= COUNT_LIMIT) && (acw_count_reg <= COUNT_LIMIT))
        else $error("step counter beyond limit");

    a_step_clears_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && do_step) |=>
            (cw_count_reg == '0) && (acw_count_reg == '0))
        else $error("counters not cleared after a step");

    a_duration_range: assert property (@(posedge clk) disable iff (!rst_n)
        duration_reg <= DUR_TOP)
        else $error("duration beyond top value");

    a_step_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.step_taken == STEP_NONE ||
                           out_data_reg.step_taken == STEP_CW ||
                           out_data_reg.step_taken == STEP_ACW))
        else $error("bad step code in result");

    a_setpoint_only_manual: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && in_data_reg.ui_mode != MODE_MANUAL) |=>
            $stable(setpoint_reg))
        else $error("setpoint moved outside manual mode");

endmodule

`default_nettype wire
